>>> rtl/wav_pcm_stream_parser_top_defines.svh
// assertion macros shared by the wav pcm stream parser rtl
`ifndef WAV_PCM_STREAM_PARSER_TOP_DEFINES_SVH
`define WAV_PCM_STREAM_PARSER_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define WAVP_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in this cycle requires consequent in the same cycle
`define WAVP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/wavp_pkg.sv
// shared types and constants for the wav pcm stream parser
package wavp_pkg;

    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = 2;
    localparam int unsigned OUT_CNT_W = 3;

    localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [4:0]  BITS_OFFSET  = 5'd14;
    localparam logic [18:0] RATE_RESET   = 19'd16000;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_RIFF   = 3'd1,
        ST_FMT_SHORT  = 3'd2,
        ST_FMT_TRUNC  = 3'd3,
        ST_DATA_TRUNC = 3'd4,
        ST_MISMATCH   = 3'd5
    } status_code_t;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_CHDR   = 7'b0000010,
        PH_FMT    = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_SKIP   = 7'b0010000,
        PH_PAD    = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic               is_status;
        logic signed [15:0] sample_value;
        logic               chunk_restart;
        status_code_t       status_code;
    } result_t;

    // expected riff/wave header bytes; the size field bytes are not checked
    function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
        logic [7:0] val;
        case (pos)
            4'd0:    val = 8'h52;
            4'd1:    val = 8'h49;
            4'd2:    val = 8'h46;
            4'd3:    val = 8'h46;
            4'd8:    val = 8'h57;
            4'd9:    val = 8'h41;
            4'd10:   val = 8'h56;
            4'd11:   val = 8'h45;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/wav_pcm_stream_parser_top.sv
// wav pcm stream parser: riff/wave walker, 16-bit sample unpacker and status reporter
//
// input channel: one file byte per transaction (data_byte, end_of_stream marks the last
// byte), flow controlled by in_valid / in_stall
// output channel: sample transactions (is_status 0) and one final status transaction
// (is_status 1), flow controlled by out_valid / out_stall
// configuration: cfg_write_en writes cfg_write_data into the expected sample rate; write it
// only while the parser is idle (the block does not enforce this); reset value 16000
// path: a byte is registered in the input register at acceptance and parsed from there
// once the queue has room; its results are written into a 4-entry output queue, whose
// registered count drives out_valid
// throughput: one byte per cycle unless in_stall holds it; each byte is parsed by a single
// pass through the chunk state logic between the input register and the output queue
// a byte makes at most two results (last sample then status); the input register
// holds while the queue has fewer than two free slots, so a stalled receiver backs
// up into in_stall and nothing is dropped
// after the status transaction all further bytes are taken and ignored
// reset (rst_n low, asynchronous) returns the parser to the riff header, empties the
// queue and restores the expected rate
`include "wav_pcm_stream_parser_top_defines.svh"

module wav_pcm_stream_parser_top
(
    input  logic               clk,
    input  logic               rst_n,

    // byte stream in
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_stream,

    // sample / status out
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_status,
    output logic signed [15:0] sample_value,
    output logic               chunk_restart,
    output logic [2:0]         status_code,

    // expected sample rate register
    input  logic               cfg_write_en,
    input  logic [18:0]        cfg_write_data
);

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    logic                       in_accept;
    logic                       advance;

    logic                       s1_valid_reg, s1_valid_next;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_eos_reg;

    logic [18:0]                rate_cfg_reg;

    wavp_pkg::phase_t           phase_reg, phase_next;
    logic [4:0]                 pos_reg, pos_next;
    logic [4:0]                 pos_inc;
    logic [31:0]                tag_reg, tag_next;
    logic [31:0]                rem_reg, rem_next;
    logic [31:0]                chunk_size;
    logic                       pad_reg, pad_next;
    logic                       found_fmt_reg, found_fmt_next;
    logic                       found_data_reg, found_data_next;
    logic [15:0]                fmt_code_reg, fmt_code_next;
    logic [15:0]                chan_reg, chan_next;
    logic [31:0]                rate_reg, rate_next;
    logic [15:0]                bits_reg, bits_next;
    logic                       data_odd_reg, data_odd_next;
    logic [7:0]                 low_hold_reg, low_hold_next;
    logic                       status_sent_reg, status_sent_next;

    logic                       chunk_end;
    logic                       final_ok;
    logic                       smp_emit;
    logic                       smp_restart;
    logic [15:0]                smp_value;
    logic                       st_emit;
    wavp_pkg::status_code_t     st_code;

    wavp_pkg::result_t          q_mem_reg [wavp_pkg::OUT_DEPTH];
    logic [wavp_pkg::OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [wavp_pkg::OUT_PTR_W-1:0] wr_ptr_alt;
    logic [wavp_pkg::OUT_CNT_W-1:0] cnt_reg;
    logic [wavp_pkg::OUT_CNT_W-1:0] push_n;
    logic                       pop;
    wavp_pkg::result_t          smp_item;
    wavp_pkg::result_t          st_item;
    wavp_pkg::result_t          head_item;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    // the parse stage retires only when the queue can absorb two results
    assign advance   = s1_valid_reg && (cnt_reg <= wavp_pkg::OUT_CNT_W'(wavp_pkg::OUT_DEPTH - 2));
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_eos_reg  <= end_of_stream;
        end
    end

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_cfg_reg <= wavp_pkg::RATE_RESET;
        end
        else if (cfg_write_en)
        begin
            rate_cfg_reg <= cfg_write_data;
        end
    end

    // ------------------------------------------------------------------
    // parse logic
    // ------------------------------------------------------------------
    // once past 16 the offset counter wraps within 16..31, which keeps the
    // parity for sample pairing and never revisits the small fmt offsets
    assign pos_inc    = pos_reg[4] ? {1'b1, pos_reg[3:0] + 4'd1} : pos_reg + 5'd1;
    assign chunk_size = {s1_byte_reg, rem_reg[23:0]};

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        tag_next         = tag_reg;
        rem_next         = rem_reg;
        pad_next         = pad_reg;
        found_fmt_next   = found_fmt_reg;
        found_data_next  = found_data_reg;
        fmt_code_next    = fmt_code_reg;
        chan_next        = chan_reg;
        rate_next        = rate_reg;
        bits_next        = bits_reg;
        data_odd_next    = data_odd_reg;
        low_hold_next    = low_hold_reg;
        status_sent_next = status_sent_reg;
        chunk_end        = 1'b0;
        final_ok         = 1'b0;
        smp_emit         = 1'b0;
        smp_restart      = 1'b0;
        smp_value        = 16'd0;
        st_emit          = 1'b0;
        st_code          = wavp_pkg::ST_OK;

        if (advance && !status_sent_reg)
        begin
            case (phase_reg)
                wavp_pkg::PH_HEADER:
                begin
                    if ((pos_reg[3:0] < 4'd4 || pos_reg[3:0] >= 4'd8) &&
                        s1_byte_reg != wavp_pkg::hdr_byte(pos_reg[3:0]))
                    begin
                        st_emit = 1'b1;
                        st_code = wavp_pkg::ST_NOT_RIFF;
                    end
                    else if (pos_reg == 5'd11)
                    begin
                        pos_next   = 5'd0;
                        phase_next = wavp_pkg::PH_CHDR;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end

                wavp_pkg::PH_CHDR:
                begin
                    if (pos_reg[2] == 1'b0)
                    begin
                        if (pos_reg[1:0] == 2'd0)
                        begin
                            tag_next = {24'd0, s1_byte_reg};
                        end
                        else
                        begin
                            tag_next[{pos_reg[1:0], 3'b000} +: 8] = s1_byte_reg;
                        end
                        pos_next = pos_inc;
                    end
                    else if (pos_reg[1:0] != 2'd3)
                    begin
                        if (pos_reg[1:0] == 2'd0)
                        begin
                            rem_next = {24'd0, s1_byte_reg};
                        end
                        else
                        begin
                            rem_next[{pos_reg[1:0], 3'b000} +: 8] = s1_byte_reg;
                        end
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        // last size byte: dispatch on the tag
                        rem_next = chunk_size;
                        pos_next = 5'd0;
                        pad_next = chunk_size[0];
                        if (tag_reg == wavp_pkg::TAG_FMT)
                        begin
                            if (chunk_size < wavp_pkg::FMT_MIN_SIZE)
                            begin
                                st_emit = 1'b1;
                                st_code = wavp_pkg::ST_FMT_SHORT;
                            end
                            else
                            begin
                                phase_next = wavp_pkg::PH_FMT;
                            end
                        end
                        else if (tag_reg == wavp_pkg::TAG_DATA)
                        begin
                            data_odd_next = chunk_size[0];
                            phase_next    = wavp_pkg::PH_DATA;
                            if (chunk_size == 32'd0)
                            begin
                                found_data_next = 1'b1;
                                chunk_end       = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = wavp_pkg::PH_SKIP;
                            if (chunk_size == 32'd0)
                            begin
                                chunk_end = 1'b1;
                            end
                        end
                    end
                end

                wavp_pkg::PH_FMT, wavp_pkg::PH_DATA, wavp_pkg::PH_SKIP:
                begin
                    if (phase_reg == wavp_pkg::PH_FMT && !pos_reg[4])
                    begin
                        if (pos_reg[3:0] < 4'd2)
                        begin
                            fmt_code_next[{pos_reg[0], 3'b000} +: 8] = s1_byte_reg;
                        end
                        else if (pos_reg[3:0] < 4'd4)
                        begin
                            chan_next[{pos_reg[0], 3'b000} +: 8] = s1_byte_reg;
                        end
                        else if (pos_reg[3:0] < 4'd8)
                        begin
                            rate_next[{pos_reg[1:0], 3'b000} +: 8] = s1_byte_reg;
                        end
                        else if (pos_reg == wavp_pkg::BITS_OFFSET ||
                                 pos_reg == wavp_pkg::BITS_OFFSET + 5'd1)
                        begin
                            bits_next[{pos_reg[0], 3'b000} +: 8] = s1_byte_reg;
                        end
                    end
                    else if (phase_reg == wavp_pkg::PH_DATA)
                    begin
                        if (!pos_reg[0])
                        begin
                            low_hold_next = s1_byte_reg;
                        end
                        else
                        begin
                            smp_emit    = 1'b1;
                            smp_value   = {s1_byte_reg, low_hold_reg};
                            smp_restart = (pos_reg == 5'd1) && found_data_reg;
                        end
                    end
                    pos_next = pos_inc;
                    rem_next = rem_reg - 32'd1;
                    if (rem_reg == 32'd1)
                    begin
                        chunk_end = 1'b1;
                        if (phase_reg == wavp_pkg::PH_FMT)
                        begin
                            found_fmt_next = 1'b1;
                        end
                        else if (phase_reg == wavp_pkg::PH_DATA)
                        begin
                            found_data_next = 1'b1;
                        end
                    end
                end

                wavp_pkg::PH_PAD:
                begin
                    pos_next   = 5'd0;
                    phase_next = wavp_pkg::PH_CHDR;
                end

                default:
                begin
                    // finished: nothing to do
                end
            endcase

            // success test on the updated chunk information
            final_ok = found_fmt_next && found_data_next &&
                       fmt_code_next == 16'd1 && chan_next == 16'd1 &&
                       rate_next == {13'd0, rate_cfg_reg} &&
                       bits_next == 16'd16 && !data_odd_next;

            if (chunk_end)
            begin
                pos_next = 5'd0;
                if (found_fmt_next && found_data_next)
                begin
                    st_emit = 1'b1;
                    st_code = final_ok ? wavp_pkg::ST_OK : wavp_pkg::ST_MISMATCH;
                end
                else
                begin
                    phase_next = pad_next ? wavp_pkg::PH_PAD : wavp_pkg::PH_CHDR;
                end
            end

            // end of stream decides by where the parse stands
            if (s1_eos_reg && !st_emit)
            begin
                st_emit = 1'b1;
                case (phase_next)
                    wavp_pkg::PH_HEADER: st_code = wavp_pkg::ST_NOT_RIFF;
                    wavp_pkg::PH_FMT:    st_code = wavp_pkg::ST_FMT_TRUNC;
                    wavp_pkg::PH_DATA:   st_code = wavp_pkg::ST_DATA_TRUNC;
                    default:
                    begin
                        st_code = final_ok ? wavp_pkg::ST_OK : wavp_pkg::ST_MISMATCH;
                    end
                endcase
            end

            if (st_emit)
            begin
                status_sent_next = 1'b1;
                phase_next       = wavp_pkg::PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= wavp_pkg::PH_HEADER;
            pos_reg         <= 5'd0;
            tag_reg         <= 32'd0;
            rem_reg         <= 32'd0;
            pad_reg         <= 1'b0;
            found_fmt_reg   <= 1'b0;
            found_data_reg  <= 1'b0;
            fmt_code_reg    <= 16'd0;
            chan_reg        <= 16'd0;
            rate_reg        <= 32'd0;
            bits_reg        <= 16'd0;
            data_odd_reg    <= 1'b0;
            low_hold_reg    <= 8'd0;
            status_sent_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            tag_reg         <= tag_next;
            rem_reg         <= rem_next;
            pad_reg         <= pad_next;
            found_fmt_reg   <= found_fmt_next;
            found_data_reg  <= found_data_next;
            fmt_code_reg    <= fmt_code_next;
            chan_reg        <= chan_next;
            rate_reg        <= rate_next;
            bits_reg        <= bits_next;
            data_odd_reg    <= data_odd_next;
            low_hold_reg    <= low_hold_next;
            status_sent_reg <= status_sent_next;
        end
    end

    // ------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------
    // a sample always goes ahead of a status made by the same byte
    assign smp_item.is_status     = 1'b0;
    assign smp_item.sample_value  = smp_value;
    assign smp_item.chunk_restart = smp_restart;
    assign smp_item.status_code   = wavp_pkg::ST_OK;

    assign st_item.is_status      = 1'b1;
    assign st_item.sample_value   = 16'sd0;
    assign st_item.chunk_restart  = 1'b0;
    assign st_item.status_code    = st_code;

    assign push_n     = wavp_pkg::OUT_CNT_W'(smp_emit) + wavp_pkg::OUT_CNT_W'(st_emit);
    assign wr_ptr_alt = wr_ptr_reg + wavp_pkg::OUT_PTR_W'(smp_emit);
    assign pop        = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (smp_emit)
        begin
            q_mem_reg[wr_ptr_reg] <= smp_item;
        end
        if (st_emit)
        begin
            q_mem_reg[wr_ptr_alt] <= st_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[wavp_pkg::OUT_PTR_W-1:0];
            rd_ptr_reg <= rd_ptr_reg + wavp_pkg::OUT_PTR_W'(pop);
            cnt_reg    <= cnt_reg + push_n - wavp_pkg::OUT_CNT_W'(pop);
        end
    end

    assign head_item     = q_mem_reg[rd_ptr_reg];
    assign out_valid     = (cnt_reg != '0);
    assign is_status     = head_item.is_status;
    assign sample_value  = head_item.sample_value;
    assign chunk_restart = head_item.chunk_restart;
    assign status_code   = head_item.status_code;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `WAVP_ASSERT_ALWAYS(a_queue_bound, cnt_reg <= wavp_pkg::OUT_CNT_W'(wavp_pkg::OUT_DEPTH), "output queue overflow")
    `WAVP_ASSERT_IMPLY(a_quiet_after_status, status_sent_reg, push_n == '0, "result after final status")
    `WAVP_ASSERT_IMPLY(a_status_origin, $rose(status_sent_reg), $past(st_emit), "status flag set without status transaction")
    `WAVP_ASSERT_IMPLY(a_restart_needs_data, smp_restart, found_data_reg && smp_emit, "restart marker on a first data chunk")

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for wav_pcm_stream_parser_top: riff/wave byte streams with an inline parse predictor
module tb;

    // clock, reset and flow-control knobs
    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned IDLE_TOP     = 12;
    localparam int unsigned STUCK_LIMIT  = 1000;
    localparam int unsigned SETTLE_WAIT  = 4;
    localparam int unsigned DRAIN_WAIT   = 16;
    localparam int unsigned RANDOM_BYTES = 800;

    // sample rate register extremes
    localparam logic [18:0] RATE_MIN = 19'd1;
    localparam logic [18:0] RATE_MAX = 19'd384000;

    // "RIFF" <size> "WAVE", byte 0 in the low bits; size bytes are never compared
    localparam logic [95:0] RIFF_WAVE_HDR = 96'h45564157_00000000_46464952;
    // an ordinary chunk the parser has to skip
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    // dut ports
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               end_of_stream;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               is_status;
    logic signed [15:0] sample_value;
    logic               chunk_restart;
    logic [2:0]         status_code;
    logic               cfg_write_en;
    logic [18:0]        cfg_write_data;

    wav_pcm_stream_parser_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_stream  (end_of_stream),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_status      (is_status),
        .sample_value   (sample_value),
        .chunk_restart  (chunk_restart),
        .status_code    (status_code),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // parse predictor: mirrors the chunk walk one byte at a time
    // ------------------------------------------------------------------

    // samples and the closing status, in the order the dut must send them
    wavp_pkg::result_t pcm_and_status_q[$];

    logic [18:0]       rate_reg      = wavp_pkg::RATE_RESET;
    wavp_pkg::phase_t  walk_phase    = wavp_pkg::PH_HEADER;
    logic [31:0]       walk_pos      = '0;
    logic [31:0]       cur_tag       = '0;
    logic [31:0]       bytes_left    = '0;
    logic              pad_due       = 1'b0;
    logic              seen_fmt      = 1'b0;
    logic              seen_data     = 1'b0;
    logic [15:0]       fmt_format    = '0;
    logic [15:0]       fmt_channels  = '0;
    logic [31:0]       fmt_rate      = '0;
    logic [15:0]       fmt_bits      = '0;
    logic              data_odd      = 1'b0;
    logic [7:0]        low_byte      = '0;
    logic              stream_closed = 1'b0;

    // accept only pcm, mono, 16-bit, matching rate and an even data body
    function automatic wavp_pkg::status_code_t verdict();
        if (seen_fmt && seen_data && fmt_format == 16'd1 && fmt_channels == 16'd1 &&
            fmt_rate == {13'd0, rate_reg} && fmt_bits == 16'd16 && !data_odd)
            return wavp_pkg::ST_OK;
        return wavp_pkg::ST_MISMATCH;
    endfunction

    // status is the last transaction; everything after it is dropped
    function automatic void close_out(input wavp_pkg::status_code_t code);
        wavp_pkg::result_t r;
        r.is_status     = 1'b1;
        r.sample_value  = '0;
        r.chunk_restart = 1'b0;
        r.status_code   = code;
        pcm_and_status_q.push_back(r);
        stream_closed = 1'b1;
        walk_phase    = wavp_pkg::PH_DONE;
    endfunction

    function automatic void close_chunk();
        walk_pos = '0;
        if (seen_fmt && seen_data)
            close_out(verdict());
        else
            walk_phase = pad_due ? wavp_pkg::PH_PAD : wavp_pkg::PH_CHDR;
    endfunction

    function automatic void end_body();
        if (walk_phase == wavp_pkg::PH_FMT)
            seen_fmt = 1'b1;
        else if (walk_phase == wavp_pkg::PH_DATA)
            seen_data = 1'b1;
        close_chunk();
    endfunction

    // tag then little-endian size; the eighth byte picks the body handling
    function automatic void take_chunk_head(input logic [7:0] b);
        int unsigned p;
        p = walk_pos & 32'd7;
        if (p < 4)
        begin
            if (p == 0)
                cur_tag = '0;
            cur_tag[8*p +: 8] = b;
        end
        else
        begin
            if (p == 4)
                bytes_left = '0;
            bytes_left[8*(p-4) +: 8] = b;
        end
        walk_pos++;
        if (p != 7)
            return;
        walk_pos = '0;
        pad_due  = bytes_left[0];
        if (cur_tag == wavp_pkg::TAG_FMT)
        begin
            if (bytes_left < wavp_pkg::FMT_MIN_SIZE)
            begin
                close_out(wavp_pkg::ST_FMT_SHORT);
                return;
            end
            walk_phase = wavp_pkg::PH_FMT;
        end
        else if (cur_tag == wavp_pkg::TAG_DATA)
        begin
            data_odd   = bytes_left[0];
            walk_phase = wavp_pkg::PH_DATA;
        end
        else
            walk_phase = wavp_pkg::PH_SKIP;
        if (bytes_left == 0)
            end_body();
    endfunction

    function automatic void take_body(input logic [7:0] b);
        logic [31:0]       off;
        logic [31:0]       bits_at;
        wavp_pkg::result_t r;
        off     = walk_pos;
        bits_at = 32'(wavp_pkg::BITS_OFFSET);
        if (walk_phase == wavp_pkg::PH_FMT)
        begin
            if (off < 2)
                fmt_format[8*off +: 8] = b;
            else if (off < 4)
                fmt_channels[8*(off-2) +: 8] = b;
            else if (off < 8)
                fmt_rate[8*(off-4) +: 8] = b;
            else if (off == bits_at || off == bits_at + 1)
                fmt_bits[8*(off-bits_at) +: 8] = b;
        end
        else if (walk_phase == wavp_pkg::PH_DATA)
        begin
            if (!off[0])
                low_byte = b;
            else
            begin
                // first sample of a chunk that replaces an earlier complete one
                r.is_status     = 1'b0;
                r.sample_value  = {b, low_byte};
                r.chunk_restart = (off == 1) && seen_data;
                r.status_code   = wavp_pkg::ST_OK;
                pcm_and_status_q.push_back(r);
            end
        end
        walk_pos++;
        bytes_left--;
        if (bytes_left == 0)
            end_body();
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic eos);
        int unsigned p;
        if (stream_closed)
            return;
        case (walk_phase)
            wavp_pkg::PH_HEADER:
            begin
                p = (walk_pos >= 12) ? 0 : walk_pos;
                if ((p < 4 || p >= 8) && b != RIFF_WAVE_HDR[8*p +: 8])
                    close_out(wavp_pkg::ST_NOT_RIFF);
                else
                begin
                    walk_pos = p + 1;
                    if (walk_pos == 12)
                    begin
                        walk_pos   = '0;
                        walk_phase = wavp_pkg::PH_CHDR;
                    end
                end
            end
            wavp_pkg::PH_CHDR:
                take_chunk_head(b);
            wavp_pkg::PH_FMT, wavp_pkg::PH_DATA, wavp_pkg::PH_SKIP:
                take_body(b);
            wavp_pkg::PH_PAD:
            begin
                walk_pos   = '0;
                walk_phase = wavp_pkg::PH_CHDR;
            end
            default:
                ;
        endcase
        // end of file: not-riff in the header, truncation codes inside fmt and data bodies, else the verdict
        if (eos && !stream_closed)
        begin
            case (walk_phase)
                wavp_pkg::PH_HEADER: close_out(wavp_pkg::ST_NOT_RIFF);
                wavp_pkg::PH_FMT:    close_out(wavp_pkg::ST_FMT_TRUNC);
                wavp_pkg::PH_DATA:   close_out(wavp_pkg::ST_DATA_TRUNC);
                default:             close_out(verdict());
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking and receiver stalls
    // ------------------------------------------------------------------

    int unsigned mismatches  = 0;
    int unsigned hold_cycles = 0;
    int unsigned stall_top   = IDLE_TOP;
    int unsigned gap_top     = IDLE_TOP;
    int unsigned sent_bytes  = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // outputs sampled at the rising edge, before the dut updates them
    always @(posedge clk)
    begin : result_check
        wavp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            hold_cycles = $urandom_range(0, stall_top);
            if (pcm_and_status_q.size() == 0)
                flag_mismatch("transaction with nothing pending", 32'(is_status), 32'd0);
            else
            begin
                want = pcm_and_status_q.pop_front();
                if (is_status !== want.is_status)
                    flag_mismatch("is_status", 32'(is_status), 32'(want.is_status));
                if (sample_value !== want.sample_value)
                    flag_mismatch("sample_value", 32'(sample_value),
                                  32'(want.sample_value));
                if (chunk_restart !== want.chunk_restart)
                    flag_mismatch("chunk_restart", 32'(chunk_restart),
                                  32'(want.chunk_restart));
                if (status_code !== want.status_code)
                    flag_mismatch("status_code", 32'(status_code), 32'(want.status_code));
            end
        end
    end

    // stall after a transaction, and now and then out of the blue
    always @(negedge clk)
    begin
        if (hold_cycles == 0 && stall_top != 0 && $urandom_range(0, 15) == 0)
            hold_cycles = $urandom_range(1, stall_top);
        if (hold_cycles != 0)
        begin
            out_stall = 1'b1;
            hold_cycles--;
        end
        else
            out_stall = 1'b0;
    end

    // ends the run when no transaction moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers; all are entered and left at a falling edge
    // ------------------------------------------------------------------

    // one byte transaction after a random gap; predicted once accepted
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        gap = $urandom_range(0, gap_top);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        data_byte     = b;
        end_of_stream = eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, eos);
        sent_bytes++;
        @(negedge clk);
    endtask

    // leans toward the sample extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] stray_tag();
        logic [31:0] t;
        t = $urandom;
        if (t == wavp_pkg::TAG_FMT || t == wavp_pkg::TAG_DATA)
            t ^= 32'h1;
        return t;
    endfunction

    task automatic send_chunk_head(input logic [31:0] tag, input logic [31:0] body_len);
        logic [63:0] head;
        head = {body_len, tag};
        for (int i = 0; i < 8; i++)
            send_byte(head[8*i +: 8], 1'b0);
    endtask

    // body bytes then the pad byte of an odd body
    task automatic send_body(input int unsigned body_len);
        for (int unsigned i = 0; i < body_len; i++)
            send_byte(pick_byte(), 1'b0);
        if (body_len % 2 == 1)
            send_byte(pick_byte(), 1'b0);
    endtask

    // register write only with the parser empty: no byte in flight, no result due
    task automatic write_rate(input logic [18:0] rate);
        in_valid = 1'b0;
        while (pcm_and_status_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = rate;
        @(negedge clk);
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        rate_reg       = rate;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // riff/wave header; a few runs corrupt one compared byte and end right there
    task automatic test_riff_header();
        int unsigned bad_at;
        logic [7:0]  b;
        bad_at = 12;
        if ($urandom_range(0, 9) == 0)
        begin
            bad_at = $urandom_range(0, 7);
            if (bad_at >= 4)
                bad_at += 4;
        end
        for (int unsigned p = 0; p < 12; p++)
        begin
            b = (p >= 4 && p < 8) ? pick_byte() : RIFF_WAVE_HDR[8*p +: 8];
            if (p == bad_at)
                b ^= 8'(1 << $urandom_range(0, 7));
            send_byte(b, 1'b0);
        end
    endtask

    // sample extremes, a padded skip chunk and an empty replacing data chunk
    task automatic test_directed_chunks();
        logic [63:0] extremes;
        if (stream_closed)
            return;
        extremes = 64'hFFFF_0000_7FFF_8000;
        send_chunk_head(wavp_pkg::TAG_DATA, 32'd8);
        for (int i = 0; i < 8; i++)
            send_byte(extremes[8*i +: 8], 1'b0);
        send_chunk_head(TAG_LIST, 32'd1);
        send_body(1);
        send_chunk_head(wavp_pkg::TAG_DATA, 32'd0);
    endtask

    // long run of data chunks (most replacing the last) and chunks to skip;
    // after an early status the bytes still go in and must all be ignored
    task automatic test_random_chunks();
        int unsigned start;
        int unsigned kind;
        int unsigned body_len;
        logic [31:0] tag;
        bit          rate_written;
        start        = sent_bytes;
        rate_written = 0;
        while (sent_bytes - start < RANDOM_BYTES)
        begin
            // stretches with no idling on either side
            gap_top   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_TOP;
            stall_top = ($urandom_range(0, 3) == 0) ? 0 : IDLE_TOP;
            kind      = $urandom_range(0, 9);
            if (kind < 6)
            begin
                body_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48);
                send_chunk_head(wavp_pkg::TAG_DATA, body_len);
                send_body(body_len);
            end
            else
            begin
                // near-miss tags on one in four skipped chunks
                tag = stray_tag();
                if (kind == 9)
                    tag = (($urandom_range(0, 1) == 0) ? wavp_pkg::TAG_DATA :
                                                         wavp_pkg::TAG_FMT) ^
                          (32'd1 << $urandom_range(0, 31));
                body_len = $urandom_range(0, 24);
                send_chunk_head(tag, body_len);
                send_body(body_len);
            end
            if (!rate_written && sent_bytes - start >= RANDOM_BYTES / 2)
            begin
                write_rate(19'($urandom_range(RATE_MIN, RATE_MAX)));
                rate_written = 1;
            end
        end
        gap_top   = IDLE_TOP;
        stall_top = IDLE_TOP;
    endtask

    // one way of closing the file: fmt after data, truncations, short fmt, early end
    task automatic test_closing_chunk();
        int unsigned  ending;
        int unsigned  body_len;
        int unsigned  cut;
        logic [18:0]  rate;
        logic [15:0]  form;
        logic [15:0]  chans;
        logic [31:0]  rate_field;
        logic [15:0]  bits;
        logic [127:0] fmt_body;
        logic [63:0]  head;
        if (stream_closed)
            return;
        case ($urandom_range(0, 3))
            0:       rate = wavp_pkg::RATE_RESET;
            1:       rate = RATE_MIN;
            2:       rate = RATE_MAX;
            default: rate = 19'($urandom_range(RATE_MIN, RATE_MAX));
        endcase
        write_rate(rate);

        // fmt fields, either all acceptable or with one field off
        form       = 16'd1;
        chans      = 16'd1;
        rate_field = {13'd0, rate};
        bits       = 16'd16;
        case ($urandom_range(0, 7))
            0: form = ($urandom_range(0, 1) == 0) ? 16'd3 : 16'hFFFE;
            1: chans = ($urandom_range(0, 1) == 0) ? 16'd2 : 16'd0;
            2: rate_field = rate_field + 32'd1;
            3: rate_field = rate_field | 32'h8000_0000;
            4: bits = ($urandom_range(0, 1) == 0) ? 16'd8 : 16'd24;
            default: ;
        endcase
        fmt_body = {bits, 16'($urandom), 32'($urandom), rate_field, chans, form};

        ending = $urandom_range(0, 9);
        if (ending < 5)
        begin
            // fresh data chunk, odd in one case, then fmt completes the file
            body_len = 2 * $urandom_range(1, 16) + ((ending == 4) ? 1 : 0);
            send_chunk_head(wavp_pkg::TAG_DATA, body_len);
            send_body(body_len);
            body_len = $urandom_range(16, 24);
            send_chunk_head(wavp_pkg::TAG_FMT, body_len);
            for (int unsigned o = 0; o < body_len; o++)
                send_byte((o < 16) ? fmt_body[8*o +: 8] : pick_byte(), 1'b0);
        end
        else if (ending == 5)
        begin
            // file ends inside the fmt body
            body_len = $urandom_range(16, 40);
            cut      = $urandom_range(1, body_len - 1);
            send_chunk_head(wavp_pkg::TAG_FMT, body_len);
            for (int unsigned o = 0; o < cut; o++)
                send_byte((o < 16) ? fmt_body[8*o +: 8] : pick_byte(), o == cut - 1);
        end
        else if (ending == 6)
            send_chunk_head(wavp_pkg::TAG_FMT, $urandom_range(0, 15));
        else if (ending == 7)
        begin
            // file ends inside a data body
            body_len = $urandom_range(2, 40);
            cut      = $urandom_range(1, body_len - 1);
            send_chunk_head(wavp_pkg::TAG_DATA, body_len);
            for (int unsigned o = 0; o < cut; o++)
                send_byte(pick_byte(), o == cut - 1);
        end
        else if (ending == 8)
        begin
            // file ends while skipping a chunk of the largest size
            send_chunk_head(stray_tag(), 32'hFFFF_FFFF);
            cut = $urandom_range(1, 20);
            for (int unsigned o = 0; o < cut; o++)
                send_byte(pick_byte(), o == cut - 1);
        end
        else
        begin
            // file ends part way through a chunk header
            head = {32'($urandom_range(0, 64)), stray_tag()};
            cut  = $urandom_range(1, 7);
            for (int unsigned o = 0; o < cut; o++)
                send_byte(head[8*o +: 8], o == cut - 1);
        end
    endtask

    // once the status is out every byte is taken and nothing comes back
    task automatic test_after_status();
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom_range(0, 255)), (i == 3) ? 1'b1 : 1'($urandom));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = '0;
        end_of_stream  = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_rate(RATE_MIN);
        test_riff_header();
        write_rate(RATE_MAX);
        test_directed_chunks();
        test_random_chunks();
        test_closing_chunk();
        test_after_status();
        in_valid = 1'b0;

        // let every pending result drain, then watch for strays
        while (pcm_and_status_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && pcm_and_status_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/wavp_pkg.sv
rtl/wav_pcm_stream_parser_top.sv
tb/sv/tb.sv
